// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_FREE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPLIT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OCCUPIED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT_ADDRESS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_LOG2_SIZE = 1'd1;

    localparam logic [31:0] MAX_SIZE = 32'h8000_0000;

    typedef struct packed {
        logic                  en;
        logic [MODE_W-1:0]     data;
    } t_mode_wr;

endpackage

// ===== rtl/bba_node_ram.sv =====
`timescale 1ns / 1ps
module bba_node_ram #(
    parameter int ADDR_W = 7,
    parameter int DEPTH  = 127
) (
    input  logic                      i_clk,
    input  bba_pkg::t_mode_wr         i_wr,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic [bba_pkg::MODE_W-1:0] o_rdata
);

    logic [bba_pkg::MODE_W-1:0] r_mem [DEPTH];
    logic [bba_pkg::MODE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_waddr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// Buddy block allocator.
// Input stream (s_axis): one request item = owner id and requested size.
// Output stream (m_axis): one result item per request = block address and status
// (0 allocated, 1 no fitting free block, 2 invalid request).
// Config channel: index 0 root address, index 1 log2 of root size; always ready.
// Sequence: an invalid owner or size goes straight to the output load. A valid
// request is accepted, then the size is rounded (one step per significant bit
// of (size - 1) plus one), then the tree is walked (one step per node visited,
// per backtrack step and per level split), then the address is formed and the
// output loaded. The node state memory has one read port, so the depth-first
// walk visits one node at a time. One request is in flight at a time.
// Reset: the node memory is swept to free, one node per cycle, over all
// 2^(TREE_LEVELS+1) - 1 nodes (127 at the default) while s_axis_tready is low.
// The result sits in an output register; a new request is taken while it waits,
// and the block holds the next result until the receiver takes the first.
module buddy_block_allocator #(
    parameter int TREE_LEVELS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // owner_id, request_size
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,  // block_address, status
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    localparam int IDX_W      = TREE_LEVELS + 1;
    localparam int POS_W      = TREE_LEVELS;
    localparam int LVL_W      = $clog2(TREE_LEVELS + 1);
    localparam int NODE_COUNT = (1 << (TREE_LEVELS + 1)) - 1;
    localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODE_COUNT - 1);
    localparam logic [4:0]       TL5       = 5'(TREE_LEVELS);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SIZE, S_EVAL, S_GROW, S_BACK, S_ADDR, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic [31:0]      r_root_addr;
    logic [4:0]       r_root_log2;
    logic [31:0]      r_val, n_val;
    logic [4:0]       r_k, n_k;
    logic [LVL_W-1:0] r_want, n_want;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_addr, n_addr;
    logic [1:0]       r_status, n_status;
    logic             r_ovalid, n_ovalid;
    logic [31:0]      r_oaddr, n_oaddr;
    logic [1:0]       r_ostatus, n_ostatus;

    bba_pkg::t_mode_wr          mode_wr;
    logic [bba_pkg::MODE_W-1:0] mode_rd;

    logic [31:0] in_owner, in_size;
    logic [4:0]  diff, finest, want5, shamt;

    assign in_owner = s_axis_tdata[31:0];
    assign in_size  = s_axis_tdata[63:32];
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_ostatus, r_oaddr};

    assign diff   = r_root_log2 - r_k;
    assign finest = (r_root_log2 < TL5) ? r_root_log2 : TL5;
    assign want5  = (diff > finest) ? finest : diff;
    assign shamt  = r_root_log2 - 5'(r_lvl);

    bba_node_ram #(
        .ADDR_W (IDX_W),
        .DEPTH  (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_wr    (mode_wr),
        .i_waddr (r_idx),
        .i_raddr (n_idx),
        .o_rdata (mode_rd)
    );

    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_k       = r_k;
        n_want    = r_want;
        n_lvl     = r_lvl;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_addr    = r_addr;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_oaddr   = r_oaddr;
        n_ostatus = r_ostatus;
        mode_wr   = '{en: 1'b0, data: bba_pkg::MODE_FREE};

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mode_wr = '{en: 1'b1, data: bba_pkg::MODE_FREE};
                if (r_idx == LAST_NODE) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_addr = '0;
                    n_k    = '0;
                    n_val  = in_size - 1'b1;
                    if (in_owner == '0 || in_size == '0 || in_size > bba_pkg::MAX_SIZE) begin
                        n_status = bba_pkg::ST_INVALID;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_SIZE;
                    end
                end
            end
            S_SIZE: begin
                if (r_val != '0) begin
                    n_val = r_val >> 1;
                    n_k   = r_k + 1'b1;
                end else if (r_k > r_root_log2) begin
                    n_status = bba_pkg::ST_INVALID;
                    n_state  = S_FIN;
                end else begin
                    n_want  = want5[LVL_W-1:0];
                    n_lvl   = '0;
                    n_idx   = '0;
                    n_pos   = '0;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (mode_rd == bba_pkg::MODE_FREE) begin
                    if (r_lvl == r_want) begin
                        mode_wr = '{en: 1'b1, data: bba_pkg::MODE_OCCUPIED};
                        n_state = S_ADDR;
                    end else begin
                        mode_wr = '{en: 1'b1, data: bba_pkg::MODE_SPLIT};
                        n_idx   = {r_idx[IDX_W-2:0], 1'b1};
                        n_pos   = r_pos << 1;
                        n_lvl   = r_lvl + 1'b1;
                        n_state = S_GROW;
                    end
                end else if (mode_rd == bba_pkg::MODE_SPLIT && r_lvl < r_want) begin
                    n_idx = {r_idx[IDX_W-2:0], 1'b1};
                    n_pos = r_pos << 1;
                    n_lvl = r_lvl + 1'b1;
                end else begin
                    n_state = S_BACK;
                end
            end
            S_GROW: begin
                // children of a free node are always free
                if (r_lvl == r_want) begin
                    mode_wr = '{en: 1'b1, data: bba_pkg::MODE_OCCUPIED};
                    n_state = S_ADDR;
                end else begin
                    mode_wr = '{en: 1'b1, data: bba_pkg::MODE_SPLIT};
                    n_idx   = {r_idx[IDX_W-2:0], 1'b1};
                    n_pos   = r_pos << 1;
                    n_lvl   = r_lvl + 1'b1;
                end
            end
            S_BACK: begin
                if (r_lvl == '0) begin
                    n_status = bba_pkg::ST_NOFIT;
                    n_state  = S_FIN;
                end else if (!r_pos[0]) begin
                    n_idx   = r_idx + 1'b1;
                    n_pos   = r_pos + 1'b1;
                    n_state = S_EVAL;
                end else begin
                    n_idx = (r_idx - 1'b1) >> 1;
                    n_pos = r_pos >> 1;
                    n_lvl = r_lvl - 1'b1;
                end
            end
            S_ADDR: begin
                n_addr   = r_root_addr + (32'(r_pos) << shamt);
                n_status = bba_pkg::ST_OK;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_oaddr   = r_addr;
                    n_ostatus = r_status;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_ovalid    <= 1'b0;
            r_root_addr <= '0;
            r_root_log2 <= 5'd20;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bba_pkg::REG_ROOT_ADDRESS:   r_root_addr <= i_cfg_data;
                    bba_pkg::REG_ROOT_LOG2_SIZE: r_root_log2 <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
        end
        r_val     <= n_val;
        r_k       <= n_k;
        r_want    <= n_want;
        r_lvl     <= n_lvl;
        r_pos     <= n_pos;
        r_addr    <= n_addr;
        r_status  <= n_status;
        r_oaddr   <= n_oaddr;
        r_ostatus <= n_ostatus;
    end

endmodule
